>>> rtl/core/sorted_priority_queue_assert.svh
// assertion macros for the sorted priority queue rtl
`ifndef SORTED_PRIORITY_QUEUE_ASSERT_SVH
`define SORTED_PRIORITY_QUEUE_ASSERT_SVH

// same-cycle implication, disabled while reset is low
`define SPQ_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("spq assertion failed");

// next-cycle implication, disabled while reset is low
`define SPQ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("spq assertion failed");

`endif

>>> rtl/core/spq_pkg.sv
// shared types and constants for the sorted priority queue
package spq_pkg;

    localparam int DEPTH = 8;
    localparam int CNT_W = $clog2(DEPTH + 1);

    typedef enum logic {
        OP_ENQ = 1'b0,
        OP_DEQ = 1'b1
    } t_op;

    typedef enum logic [1:0] {
        ST_ENQ   = 2'd0,
        ST_DEQ   = 2'd1,
        ST_FULL  = 2'd2,
        ST_EMPTY = 2'd3
    } t_status;

    typedef struct packed {
        logic        [15:0] prio;
        logic        [15:0] order;
        logic signed [31:0] value;
    } t_entry;

    // per-cycle command broadcast to every cell
    typedef struct packed {
        logic enq;
        logic deq;
    } t_cell_ctl;

endpackage

>>> rtl/core/spq_cell.sv
// one slot of the sorted chain: holds an entry and shifts with its neighbors
module spq_cell (
    input  logic              i_clk,
    input  spq_pkg::t_cell_ctl i_ctl,
    input  logic              i_occupied,
    input  spq_pkg::t_entry   i_new,
    input  spq_pkg::t_entry   i_left,
    input  logic              i_left_stays,
    input  spq_pkg::t_entry   i_right,
    output spq_pkg::t_entry   o_entry,
    output logic              o_stays
);

    spq_pkg::t_entry r_entry;
    spq_pkg::t_entry n_entry;

    // stored entry is ahead of the new key: smaller priority, or equal and not later
    always_comb begin
        o_stays = i_occupied &&
                  ((r_entry.prio < i_new.prio) ||
                   ((r_entry.prio == i_new.prio) && (r_entry.order <= i_new.order)));
    end

    always_comb begin
        n_entry = r_entry;
        if (i_ctl.enq) begin
            if (o_stays) begin
                n_entry = r_entry;
            end else if (i_left_stays) begin
                n_entry = i_new;
            end else begin
                n_entry = i_left;
            end
        end else if (i_ctl.deq) begin
            n_entry = i_right;
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

    assign o_entry = r_entry;

endmodule

>>> rtl/core/sorted_priority_queue.sv
// sorted priority queue top level: cell chain, fill count and result register
//
//  channel  direction  handshake           payload
//  input    in         i_valid / o_stall   i_operation i_priority_req i_arrival_order i_item_value
//  output   out        o_valid / i_stall   o_status o_out_priority o_out_order o_out_value
//
// one transaction per cycle while the input is not stalled: every cell compares its
// entry with the new key in parallel, so an enqueue or dequeue finishes in the cycle it
// is accepted. the result appears in the cycle after acceptance, from a single output
// register. synchronous active-low reset empties the queue and the output register.
// input is stalled only while a result waits and the output side is stalled.
`include "sorted_priority_queue_assert.svh"

module sorted_priority_queue (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic               i_operation,
    input  logic        [15:0] i_priority_req,
    input  logic        [15:0] i_arrival_order,
    input  logic signed [31:0] i_item_value,
    output logic               o_valid,
    input  logic               i_stall,
    output logic        [1:0]  o_status,
    output logic        [15:0] o_out_priority,
    output logic        [15:0] o_out_order,
    output logic signed [31:0] o_out_value
);

    localparam logic [spq_pkg::CNT_W-1:0] FULL_CNT = spq_pkg::CNT_W'(spq_pkg::DEPTH);

    // control state
    logic [spq_pkg::CNT_W-1:0] r_count;
    logic [spq_pkg::CNT_W-1:0] n_count;
    logic                      r_out_valid;
    logic                      n_out_valid;

    // result payload
    spq_pkg::t_status r_status;
    spq_pkg::t_status n_status;
    spq_pkg::t_entry  r_out;
    spq_pkg::t_entry  n_out;

    logic               w_accept;
    logic               w_is_deq;
    logic               w_full;
    logic               w_empty;
    spq_pkg::t_cell_ctl w_ctl;
    spq_pkg::t_entry    w_new;
    spq_pkg::t_entry    w_entry [spq_pkg::DEPTH];
    logic               w_stays [spq_pkg::DEPTH];

    // output register frees up when empty or when its transaction leaves
    assign o_stall  = r_out_valid && i_stall;
    assign w_accept = i_valid && !o_stall;

    assign w_is_deq = (i_operation == spq_pkg::OP_DEQ);
    assign w_full   = (r_count == FULL_CNT);
    assign w_empty  = (r_count == '0);

    // overflow and underflow leave the chain untouched
    assign w_ctl.enq = w_accept && !w_is_deq && !w_full;
    assign w_ctl.deq = w_accept && w_is_deq && !w_empty;

    assign w_new.prio  = i_priority_req;
    assign w_new.order = i_arrival_order;
    assign w_new.value = i_item_value;

    // cell 0 is the head; an entry moves right on insert and left on removal
    for (genvar k = 0; k < spq_pkg::DEPTH; k++) begin : g_cell
        spq_pkg::t_entry w_left;
        logic            w_left_stays;
        spq_pkg::t_entry w_right;

        if (k == 0) begin : g_head
            assign w_left       = w_new;
            assign w_left_stays = 1'b1;
        end else begin : g_mid
            assign w_left       = w_entry[k-1];
            assign w_left_stays = w_stays[k-1];
        end

        if (k == spq_pkg::DEPTH - 1) begin : g_tail
            assign w_right = w_entry[k];
        end else begin : g_body
            assign w_right = w_entry[k+1];
        end

        spq_cell u_cell (
            .i_clk        (i_clk),
            .i_ctl        (w_ctl),
            .i_occupied   (spq_pkg::CNT_W'(k) < r_count),
            .i_new        (w_new),
            .i_left       (w_left),
            .i_left_stays (w_left_stays),
            .i_right      (w_right),
            .o_entry      (w_entry[k]),
            .o_stays      (w_stays[k])
        );
    end

    always_comb begin
        n_count = r_count;
        if (w_ctl.enq) begin
            n_count = r_count + 1'b1;
        end else if (w_ctl.deq) begin
            n_count = r_count - 1'b1;
        end
    end

    // result register: load on accept, drop when the output side takes it
    always_comb begin
        n_out_valid = r_out_valid;
        n_status    = r_status;
        n_out       = r_out;
        if (w_accept) begin
            n_out_valid = 1'b1;
            n_out       = '0;
            if (w_is_deq) begin
                if (w_empty) begin
                    n_status = spq_pkg::ST_EMPTY;
                end else begin
                    n_status = spq_pkg::ST_DEQ;
                    n_out    = w_entry[0];
                end
            end else begin
                n_status = w_full ? spq_pkg::ST_FULL : spq_pkg::ST_ENQ;
            end
        end else if (r_out_valid && !i_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_status <= n_status;
        r_out    <= n_out;
    end

    assign o_valid        = r_out_valid;
    assign o_status       = r_status;
    assign o_out_priority = r_out.prio;
    assign o_out_order    = r_out.order;
    assign o_out_value    = r_out.value;

    // fill count stays within the chain length
    `SPQ_ASSERT_IMPL(a_count_bound, i_clk, i_rst_n, 1'b1, r_count <= FULL_CNT)

    // head never sorts after its neighbor
    `SPQ_ASSERT_IMPL(a_head_sorted, i_clk, i_rst_n, r_count >= 2,
        (w_entry[0].prio < w_entry[1].prio) ||
        ((w_entry[0].prio == w_entry[1].prio) && (w_entry[0].order <= w_entry[1].order)))

    // a dequeue from a nonempty queue reports a dequeued entry next cycle
    `SPQ_ASSERT_NEXT(a_deq_status, i_clk, i_rst_n, w_ctl.deq,
        r_out_valid && (r_status == spq_pkg::ST_DEQ))

    // a successful enqueue grows the count by exactly one
    `SPQ_ASSERT_NEXT(a_enq_count, i_clk, i_rst_n, w_ctl.enq,
        r_count == $past(r_count) + 1'b1)

endmodule
